// ----- hw/rtl/oaht_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table package
// Shared widths, codes, request layout and state types for the open
// addressing hash table.
// ----------------------------------------------------------------------------
package oaht_pkg;

    // Field widths of one request and one result.
    localparam int ACTION_W = 2;
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 4;
    localparam int TAG_W    = 2;

    // Stream bus widths, padded to whole bytes.
    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;

    // Hash datapath: one key byte per cycle, then a reciprocal multiply
    // that yields the home slot.
    localparam int HASH_W     = 32;
    localparam int HASH_BYTES = KEY_W / 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_DELETE = 2'd2
    } action_t;

    typedef enum logic [TAG_W-1:0] {
        TAG_EMPTY    = 2'd0,
        TAG_OCCUPIED = 2'd1,
        TAG_DELETED  = 2'd2
    } tag_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // Request as it sits in the input beat, action in the lowest bits.
    typedef struct packed {
        logic [VALUE_W-1:0]  value;
        logic [LEN_W-1:0]    len;
        logic [KEY_W-1:0]    key;
        logic [ACTION_W-1:0] action;
    } req_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_HASH,
        F_MOD,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_PROBE,
        B_DONE
    } back_state_t;

endpackage

// ----- hw/rtl/oaht_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table front end
// Accepts a request beat, trims the key to its effective length, hashes it
// one byte per cycle and reduces the hash to a home slot with a reciprocal
// multiplication.
// ----------------------------------------------------------------------------
module oaht_front #(
    parameter int SLOTS     = 16,
    parameter int KEY_BYTES = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [oaht_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            clear_busy,
    output logic                            push_valid,
    input  logic                            push_ready,
    output oaht_pkg::req_t                  push_req,
    output logic [$clog2(SLOTS)-1:0]        push_home
);
    import oaht_pkg::*;

    localparam int SLOT_W  = $clog2(SLOTS);
    localparam int BCNT_W  = $clog2(HASH_BYTES + 1);
    localparam int RECIP_W = HASH_W + 1;
    // Rounded-up reciprocal of the slot count, exact for every 32-bit hash.
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << (HASH_W + SLOT_W)) / 64'(SLOTS)) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_FULL);
    localparam logic [SLOT_W-1:0]  SLOTS_LOW = SLOT_W'(SLOTS);

    front_state_t        state_reg, state_next;
    req_t                req_reg, req_next;
    logic [KEY_W-1:0]    hkey_reg, hkey_next;
    logic [BCNT_W-1:0]   hcnt_reg, hcnt_next;
    logic                zero_hash_reg, zero_hash_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [SLOT_W-1:0]   quot_reg, quot_next;

    req_t                in_req;
    logic [LEN_W-1:0]    eff_len;
    logic [KEY_W-1:0]    key_mask;
    logic [BCNT_W-1:0]   hash_len;
    logic [7:0]          hbyte;
    logic [HASH_W-1:0]   hsum;
    logic [HASH_W+7:0]   hprod;
    logic [HASH_W+RECIP_W-1:0] mod_prod;

    // Decode the incoming beat: saturate the length and clear unused bytes.
    always_comb begin
        in_req = s_tdata[$bits(req_t)-1:0];
        if (int'(in_req.len) > KEY_BYTES) begin
            eff_len = LEN_W'(KEY_BYTES);
        end else begin
            eff_len = in_req.len;
        end
        for (int i = 0; i < HASH_BYTES; i++) begin
            key_mask[8*i +: 8] = (i < int'(eff_len)) ? 8'hFF : 8'h00;
        end
        // Bytes past the key field are zero, which forces the hash to zero.
        if (int'(eff_len) > HASH_BYTES) begin
            hash_len = BCNT_W'(HASH_BYTES);
        end else begin
            hash_len = BCNT_W'(eff_len);
        end
    end

    // One hash step: add the byte, then multiply by it.
    always_comb begin
        hbyte = hkey_reg[7:0];
        hsum  = hash_reg + HASH_W'(hbyte);
        hprod = hsum * hbyte;
    end

    // Quotient of the hash by the slot count through the reciprocal.
    assign mod_prod = hash_reg * RECIP;

    // Sequencer: accept, hash, reduce, hand over to the queue.
    always_comb begin
        state_next     = state_reg;
        req_next       = req_reg;
        hkey_next      = hkey_reg;
        hcnt_next      = hcnt_reg;
        zero_hash_next = zero_hash_reg;
        hash_next      = hash_reg;
        quot_next      = quot_reg;
        s_tready       = 1'b0;
        push_valid     = 1'b0;
        case (state_reg)
            F_IDLE: begin
                s_tready = !clear_busy;
                if (s_tvalid && !clear_busy) begin
                    req_next.action = in_req.action;
                    req_next.key    = in_req.key & key_mask;
                    req_next.len    = eff_len;
                    req_next.value  = in_req.value;
                    hkey_next       = in_req.key & key_mask;
                    hcnt_next       = hash_len;
                    zero_hash_next  = int'(eff_len) > HASH_BYTES;
                    hash_next       = '0;
                    state_next      = F_HASH;
                end
            end
            F_HASH: begin
                if (hcnt_reg == '0) begin
                    hash_next  = zero_hash_reg ? '0 : hash_reg;
                    state_next = F_MOD;
                end else begin
                    hash_next = hprod[HASH_W-1:0];
                    hkey_next = hkey_reg >> 8;
                    hcnt_next = hcnt_reg - 1'b1;
                end
            end
            F_MOD: begin
                // Only the low quotient bits matter for the remainder.
                quot_next  = mod_prod[HASH_W+SLOT_W +: SLOT_W];
                state_next = F_PUSH;
            end
            F_PUSH: begin
                push_valid = 1'b1;
                if (push_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    // The remainder is below the slot count, so its low bits are exact.
    assign push_req  = req_reg;
    assign push_home = hash_reg[SLOT_W-1:0] - quot_reg * SLOTS_LOW;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        hkey_reg      <= hkey_next;
        hcnt_reg      <= hcnt_next;
        zero_hash_reg <= zero_hash_next;
        hash_reg      <= hash_next;
        quot_reg      <= quot_next;
    end

endmodule

// ----- hw/rtl/oaht_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table request queue
// Small first-in first-out buffer that decouples the hashing front end from
// the probing back end.
// ----------------------------------------------------------------------------
module oaht_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [DATA_W-1:0] fifo_mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = count_reg != CNT_FULL;
    assign pop_valid  = count_reg != '0;
    assign pop_data   = fifo_mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            fifo_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- hw/rtl/oaht_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hash table back end
// Holds the slot memories, clears the tags after reset, and runs the linear
// probe for one request at a time, issuing one slot read per cycle.
// ----------------------------------------------------------------------------
module oaht_back #(
    parameter int SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  oaht_pkg::req_t                  pop_req,
    input  logic [$clog2(SLOTS)-1:0]        pop_home,
    output logic                            clear_busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [oaht_pkg::M_TDATA_W-1:0]  m_tdata
);
    import oaht_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int PAD_W  = M_TDATA_W - STATUS_W - INDEX_W - VALUE_W;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
    localparam logic [CNT_W-1:0]  ALL_SLOTS = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0]  LAST_CNT  = CNT_W'(SLOTS - 1);

    back_state_t           state_reg, state_next;
    logic [SLOT_W-1:0]     clr_addr_reg, clr_addr_next;
    req_t                  req_reg, req_next;
    logic [SLOT_W-1:0]     probe_addr_reg, probe_addr_next;
    logic [CNT_W-1:0]      issue_cnt_reg, issue_cnt_next;
    logic [CNT_W-1:0]      eval_cnt_reg, eval_cnt_next;
    logic                  rd_vld_reg, rd_vld_next;
    logic [SLOT_W-1:0]     rd_slot_reg, rd_slot_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [SLOT_W-1:0]     res_slot_reg, res_slot_next;
    logic [VALUE_W-1:0]    res_value_reg, res_value_next;
    logic                  m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0]  m_data_reg, m_data_next;

    // Slot memories; only the tags are cleared.
    logic [TAG_W-1:0]      tag_mem [SLOTS];
    logic [KEY_W-1:0]      key_mem [SLOTS];
    logic [LEN_W-1:0]      len_mem [SLOTS];
    logic [VALUE_W-1:0]    val_mem [SLOTS];
    logic [TAG_W-1:0]      tag_q;
    logic [KEY_W-1:0]      key_q;
    logic [LEN_W-1:0]      len_q;
    logic [VALUE_W-1:0]    val_q;

    logic                  tag_we;
    logic [SLOT_W-1:0]     tag_waddr;
    logic [TAG_W-1:0]      tag_wdata;
    logic                  entry_we;
    logic                  key_match;
    logic                  probe_done;
    logic [SLOT_W+INDEX_W-1:0] slot_ext;

    assign key_match  = (len_q == req_reg.len) && (key_q == req_reg.key);
    assign slot_ext   = {{INDEX_W{1'b0}}, res_slot_reg};
    assign clear_busy = state_reg == B_CLEAR;
    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;

    // Clearing pass, request pickup, probe evaluation and result handoff.
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        req_next        = req_reg;
        probe_addr_next = probe_addr_reg;
        issue_cnt_next  = issue_cnt_reg;
        eval_cnt_next   = eval_cnt_reg;
        rd_vld_next     = 1'b0;
        rd_slot_next    = rd_slot_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        res_value_next  = res_value_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        pop_ready       = 1'b0;
        tag_we          = 1'b0;
        tag_waddr       = rd_slot_reg;
        tag_wdata       = TAG_EMPTY;
        entry_we        = 1'b0;
        probe_done      = 1'b0;
        case (state_reg)
            B_CLEAR: begin
                tag_we    = 1'b1;
                tag_waddr = clr_addr_reg;
                tag_wdata = TAG_EMPTY;
                if (clr_addr_reg == LAST_SLOT) begin
                    state_next = B_IDLE;
                end else begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end
            B_IDLE: begin
                pop_ready = 1'b1;
                if (pop_valid) begin
                    req_next        = pop_req;
                    probe_addr_next = pop_home;
                    issue_cnt_next  = '0;
                    eval_cnt_next   = '0;
                    res_slot_next   = '0;
                    res_value_next  = '0;
                    if (pop_req.action == ACT_INSERT) begin
                        res_status_next = ST_FULL;
                        state_next      = B_PROBE;
                    end else if (pop_req.action == ACT_LOOKUP ||
                                 pop_req.action == ACT_DELETE) begin
                        res_status_next = ST_NOT_FOUND;
                        state_next      = B_PROBE;
                    end else begin
                        // Unused action code: answer not found at once.
                        res_status_next = ST_NOT_FOUND;
                        state_next      = B_DONE;
                    end
                end
            end
            B_PROBE: begin
                // Issue the next slot read while earlier reads are judged.
                if (issue_cnt_reg != ALL_SLOTS) begin
                    rd_vld_next     = 1'b1;
                    rd_slot_next    = probe_addr_reg;
                    probe_addr_next = (probe_addr_reg == LAST_SLOT) ? '0
                                                                    : probe_addr_reg + 1'b1;
                    issue_cnt_next  = issue_cnt_reg + 1'b1;
                end
                if (rd_vld_reg) begin
                    eval_cnt_next = eval_cnt_reg + 1'b1;
                    if (req_reg.action == ACT_INSERT) begin
                        if (tag_q != TAG_OCCUPIED) begin
                            tag_we          = 1'b1;
                            tag_waddr       = rd_slot_reg;
                            tag_wdata       = TAG_OCCUPIED;
                            entry_we        = 1'b1;
                            res_status_next = ST_OK;
                            res_slot_next   = rd_slot_reg;
                            probe_done      = 1'b1;
                        end
                    end else if (tag_q == TAG_EMPTY) begin
                        probe_done = 1'b1;
                    end else if (tag_q == TAG_OCCUPIED && key_match) begin
                        res_status_next = ST_OK;
                        res_slot_next   = rd_slot_reg;
                        res_value_next  = val_q;
                        probe_done      = 1'b1;
                        if (req_reg.action == ACT_DELETE) begin
                            tag_we    = 1'b1;
                            tag_waddr = rd_slot_reg;
                            tag_wdata = TAG_DELETED;
                        end
                    end
                    // A full pass without a decision keeps the default answer.
                    if (eval_cnt_reg == LAST_CNT) begin
                        probe_done = 1'b1;
                    end
                    if (probe_done) begin
                        rd_vld_next = 1'b0;
                        state_next  = B_DONE;
                    end
                end
            end
            B_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = {{PAD_W{1'b0}}, res_value_reg,
                                    slot_ext[INDEX_W-1:0], res_status_reg};
                    m_valid_next = 1'b1;
                    state_next   = B_IDLE;
                end
            end
            default: begin
                state_next = B_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_CLEAR;
            clr_addr_reg  <= '0;
            issue_cnt_reg <= '0;
            eval_cnt_reg  <= '0;
            rd_vld_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            issue_cnt_reg <= issue_cnt_next;
            eval_cnt_reg  <= eval_cnt_next;
            rd_vld_reg    <= rd_vld_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        probe_addr_reg <= probe_addr_next;
        rd_slot_reg    <= rd_slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        res_value_reg  <= res_value_next;
        m_data_reg     <= m_data_next;
    end

    // Slot memories: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (entry_we) begin
            key_mem[rd_slot_reg] <= req_reg.key;
            len_mem[rd_slot_reg] <= req_reg.len;
            val_mem[rd_slot_reg] <= req_reg.value;
        end
        tag_q <= tag_mem[probe_addr_reg];
        key_q <= key_mem[probe_addr_reg];
        len_q <= len_mem[probe_addr_reg];
        val_q <= val_mem[probe_addr_reg];
    end

`ifndef SYNTHESIS
    // The probe never issues more reads than there are slots.
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_cnt_reg <= ALL_SLOTS)
        else $error("probe issued more reads than slots");

    // Every judged slot was issued first.
    a_eval_behind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == B_PROBE) |-> (eval_cnt_reg <= issue_cnt_reg))
        else $error("probe judged a slot that was never read");

    // A slot becomes occupied only through an insert probe.
    a_occupy_insert: assert property (@(posedge aclk) disable iff (!aresetn)
        (tag_we && tag_wdata == TAG_OCCUPIED) |->
        (state_reg == B_PROBE && req_reg.action == ACT_INSERT))
        else $error("slot occupied outside an insert");

    // A new result beat only follows a finished request.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == B_DONE))
        else $error("result beat without a finished request");
`endif

endmodule

// ----- hw/rtl/open_addressing_hash_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Open addressing hash table
// Linear probing table with tombstones, keyed by up to eight bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Each s_ beat carries one request (insert, lookup or delete); each request
//   yields exactly one m_ beat with status, slot index and found payload.
//   The front end hashes one key byte per cycle, then reduces the 32-bit hash
//   to a home slot with one reciprocal multiply. The back end probes one slot
//   per cycle on the single table read port. A queue between the two lets
//   them overlap, so the sustained rate is set by the slower of the two.
//   After reset the tag memory is cleared one slot per cycle; s_tready stays
//   low until the clear is done. A stalled m_ side holds the result in the
//   output register; the back end and queue keep working until they fill,
//   after which s_tready drops.
// ----------------------------------------------------------------------------
module open_addressing_hash_table #(
    parameter int SLOTS       = 16,
    parameter int KEY_BYTES   = 8,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: action[1:0], key_bytes[65:2], key_length[69:66],
    //          entry_value[85:70], zero padding [87:86]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [oaht_pkg::S_TDATA_W-1:0]  s_tdata,
    // m_tdata: status[1:0], slot_index[5:2], found_value[21:6],
    //          zero padding [23:22]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [oaht_pkg::M_TDATA_W-1:0]  m_tdata
);
    import oaht_pkg::*;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int REQ_W  = $bits(req_t);
    localparam int Q_W    = REQ_W + SLOT_W;

    logic               push_valid, push_ready;
    req_t               push_req;
    logic [SLOT_W-1:0]  push_home;
    logic               pop_valid, pop_ready;
    req_t               pop_req;
    logic [SLOT_W-1:0]  pop_home;
    logic [Q_W-1:0]     q_in, q_out;
    logic               clear_busy;

    assign q_in     = {push_home, push_req};
    assign pop_req  = q_out[REQ_W-1:0];
    assign pop_home = q_out[Q_W-1 -: SLOT_W];

    // Hashing front end.
    oaht_front #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .clear_busy (clear_busy),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_req   (push_req),
        .push_home  (push_home)
    );

    // Request queue between the two halves.
    oaht_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (q_in),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (q_out)
    );

    // Probing back end with the slot memories.
    oaht_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_req    (pop_req),
        .pop_home   (pop_home),
        .clear_busy (clear_busy),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule
